FILE: hdl/ipid_pkg.sv
// Package for the integer PID controller: state encoding, register indexes,
// datapath widths and saturation limits.
// No dependencies; the controller, the divider and the testbench import it.
package ipid_pkg;

  // Widths of the configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_SCALE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DERIVATIVE_SCALE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT   = 3'd6;

  // Shared divider: 48-bit unsigned dividend, 16-bit divisor, two bits per cycle.
  localparam int DIV_W       = 48;
  localparam int DIVISOR_W   = 16;
  localparam int DIV_STEPS   = DIV_W / 2;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // Shared multiplier operand widths.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Saturation limits.
  localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;
  localparam logic signed [31:0] D_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] D_MIN   = 32'sh8000_0000;

  // Reset values of the configuration registers.
  localparam logic [15:0] TIME_STEP_RST      = 16'd1;
  localparam logic [15:0] INTEGRAL_SCALE_RST = 16'd1;
  localparam logic [15:0] DERIV_SCALE_RST    = 16'd1;
  localparam logic [14:0] INTEGRAL_LIMIT_RST = 15'h7FFF;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_INT,
    S_ACC,
    S_DIV_INT_GO,
    S_DIV_INT,
    S_MUL_DER,
    S_DIV_DER_GO,
    S_DIV_DER,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_SUM
  } ipid_state_t;

endpackage

FILE: hdl/ipid_if.sv
// Handshake channels of the integer PID controller: sample requests in and
// result requests out, each with valid, ready and payload.
// Depends on nothing.
interface ipid_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] target_value;
  logic signed [15:0] measured_value;

  modport source (output valid, target_value, measured_value, input ready);
  modport sink (input valid, target_value, measured_value, output ready);
endinterface

interface ipid_result_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] drive_total;
  logic signed [31:0] term_p;
  logic signed [31:0] term_i;
  logic signed [47:0] term_d;

  modport source (output valid, drive_total, term_p, term_i, term_d, input ready);
  modport sink (input valid, drive_total, term_p, term_i, term_d, output ready);
endinterface

FILE: hdl/integer_pid_controller.sv
// Top level of the integer PID controller: sequencer, shared multiplier,
// configuration registers and result register.
// Depends on ipid_pkg, ipid_if (channel interfaces) and ipid_div.

// Each sample request carries a setpoint and a measurement and yields exactly one result
// request with the proportional, integral and derivative terms and their saturated sum.
// The block works on one sample at a time and spends most of that time in the shared
// divider: it delivers two quotient bits per cycle and runs twice per sample (a start
// step, the quotient bits and a step to take the quotient), once to scale the integral
// accumulator and once to divide the error change by the time step. The five products
// go through a single 33 by 18 bit multiplier, one per cycle; the remaining steps are
// the accumulate step, the summing step and the step in which the sample is accepted.
// A finished result waits in an output register, so the next sample may be accepted
// while the previous result has not yet been taken; only the final summing step stalls
// if that register is still occupied. Configuration registers are written through
// cfg_write, cfg_index and cfg_data; the user must write them only while no sample is
// in flight, and the block itself does not enforce this. Writes to an index beyond the
// register list are ignored. A time step or integral scale of zero is treated as one.
module integer_pid_controller
  import ipid_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ipid_sample_if.sink            sample,
  ipid_result_if.source          result
);

  // Configuration registers.
  logic signed [15:0] gain_p;
  logic signed [15:0] gain_i;
  logic signed [15:0] gain_d;
  logic [15:0]        time_step;
  logic [15:0]        integral_scale;
  logic [15:0]        derivative_scale;
  logic [14:0]        integral_limit;

  // Controller state.
  logic signed [17:0] last_error;
  logic signed [47:0] acc;

  // Per-sample working registers.
  logic signed [16:0] error;
  logic signed [17:0] diff;
  logic signed [32:0] inc;
  logic signed [34:0] dprod;
  logic signed [15:0] iterm;
  logic signed [31:0] deriv;
  logic signed [31:0] tp;
  logic signed [31:0] ti;
  logic signed [47:0] td;

  ipid_state_t state, state_next;

  // Divider connections and sequencer strobes.
  logic               div_start;
  logic               div_done;
  logic [DIV_W-1:0]   div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  logic [DIV_W-1:0]   div_quotient;
  logic               out_load;

  // Shared multiplier.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  logic [15:0]        dt_eff;
  logic [15:0]        iscale_eff;
  logic [DIV_W-1:0]   acc_mag;
  logic [34:0]        dprod_mag;
  logic signed [16:0] error_in;
  logic signed [48:0] acc_sum;
  logic signed [47:0] acc_sat;
  logic signed [48:0] total_sum;
  logic signed [47:0] total_sat;
  logic [DIV_W-1:0]   limit_ext;
  logic [14:0]        iclamp;
  logic signed [31:0] deriv_sat;

  assign dt_eff     = (time_step == 16'd0) ? 16'd1 : time_step;
  assign iscale_eff = (integral_scale == 16'd0) ? 16'd1 : integral_scale;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p           <= '0;
      gain_i           <= '0;
      gain_d           <= '0;
      time_step        <= TIME_STEP_RST;
      integral_scale   <= INTEGRAL_SCALE_RST;
      derivative_scale <= DERIV_SCALE_RST;
      integral_limit   <= INTEGRAL_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GAIN_P:           gain_p           <= $signed(cfg_data);
        REG_GAIN_I:           gain_i           <= $signed(cfg_data);
        REG_GAIN_D:           gain_d           <= $signed(cfg_data);
        REG_TIME_STEP:        time_step        <= cfg_data;
        REG_INTEGRAL_SCALE:   integral_scale   <= cfg_data;
        REG_DERIVATIVE_SCALE: derivative_scale <= cfg_data;
        REG_INTEGRAL_LIMIT:   integral_limit   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:       if (sample.valid) state_next = S_MUL_INT;
      S_MUL_INT:    state_next = S_ACC;
      S_ACC:        state_next = S_DIV_INT_GO;
      S_DIV_INT_GO: state_next = S_DIV_INT;
      S_DIV_INT:    if (div_done) state_next = S_MUL_DER;
      S_MUL_DER:    state_next = S_DIV_DER_GO;
      S_DIV_DER_GO: state_next = S_DIV_DER;
      S_DIV_DER:    if (div_done) state_next = S_MUL_P;
      S_MUL_P:      state_next = S_MUL_I;
      S_MUL_I:      state_next = S_MUL_D;
      S_MUL_D:      state_next = S_SUM;
      S_SUM:        if (!result.valid || result.ready) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Magnitudes handed to the divider; the most negative accumulator value wraps to 2^47,
  // which is still correct as an unsigned magnitude.
  assign acc_mag   = acc[47] ? DIV_W'(-acc) : DIV_W'(acc);
  assign dprod_mag = dprod[34] ? 35'(-dprod) : 35'(dprod);

  // Output logic of the sequencer: operand selection and strobes.
  always_comb begin
    sample.ready = 1'b0;
    div_start    = 1'b0;
    div_dividend = acc_mag;
    div_divisor  = iscale_eff;
    out_load     = 1'b0;
    mul_a        = MUL_A_W'(error);
    mul_b        = $signed({2'b00, dt_eff});
    case (state)
      S_IDLE:       sample.ready = 1'b1;
      S_MUL_INT: begin
        mul_a = MUL_A_W'(error);
        mul_b = $signed({2'b00, dt_eff});
      end
      S_DIV_INT_GO: begin
        div_start    = 1'b1;
        div_dividend = acc_mag;
        div_divisor  = iscale_eff;
      end
      S_MUL_DER: begin
        mul_a = MUL_A_W'(diff);
        mul_b = $signed({2'b00, derivative_scale});
      end
      S_DIV_DER_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(dprod_mag);
        div_divisor  = dt_eff;
      end
      S_MUL_P: begin
        mul_a = MUL_A_W'(error);
        mul_b = MUL_B_W'(gain_p);
      end
      S_MUL_I: begin
        mul_a = MUL_A_W'(iterm);
        mul_b = MUL_B_W'(gain_i);
      end
      S_MUL_D: begin
        mul_a = MUL_A_W'(deriv);
        mul_b = MUL_B_W'(gain_d);
      end
      S_SUM:        out_load = !result.valid || result.ready;
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  ipid_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Error of the incoming sample, sign-extended before subtracting.
  assign error_in = 17'(sample.target_value) - 17'(sample.measured_value);

  // Saturating accumulator update; the increment is at most 33 bits, so one extra bit
  // is enough to detect overflow.
  always_comb begin
    acc_sum = 49'(acc) + 49'(inc);
    if (acc_sum[48] != acc_sum[47]) begin
      acc_sat = acc_sum[48] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sat = acc_sum[47:0];
    end
  end

  // Integral term: quotient magnitude clamped to the limit, sign taken from the accumulator.
  assign limit_ext = DIV_W'(integral_limit);
  assign iclamp    = (div_quotient > limit_ext) ? integral_limit : div_quotient[14:0];

  // Derivative: quotient magnitude saturated to the 32-bit signed range.
  always_comb begin
    if (dprod[34]) begin
      if (div_quotient > DIV_W'(33'h0_8000_0000)) begin
        deriv_sat = D_MIN;
      end else begin
        deriv_sat = 32'(-$signed({1'b0, div_quotient[31:0]}));
      end
    end else begin
      if (div_quotient > DIV_W'(D_MAX)) begin
        deriv_sat = D_MAX;
      end else begin
        deriv_sat = $signed(div_quotient[31:0]);
      end
    end
  end

  // Final sum of the three terms, saturated to 48 bits.
  always_comb begin
    total_sum = 49'(tp) + 49'(ti) + 49'(td);
    if (total_sum[48] != total_sum[47]) begin
      total_sat = total_sum[48] ? ACC_MIN : ACC_MAX;
    end else begin
      total_sat = total_sum[47:0];
    end
  end

  // Controller state: cleared by reset, updated once per accepted sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      acc        <= '0;
    end else begin
      if (state == S_IDLE && sample.valid) begin
        last_error <= 18'(error_in);
      end
      if (state == S_ACC) begin
        acc <= acc_sat;
      end
    end
  end

  // Working registers; each product is registered before it is used again.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (sample.valid) begin
          error <= error_in;
          diff  <= 18'(error_in) - last_error;
        end
      end
      S_MUL_INT: inc   <= mul_p[32:0];
      S_DIV_INT: begin
        if (div_done) begin
          iterm <= acc[47] ? 16'(-$signed({1'b0, iclamp})) : $signed({1'b0, iclamp});
        end
      end
      S_MUL_DER: dprod <= mul_p[34:0];
      S_DIV_DER: begin
        if (div_done) begin
          deriv <= deriv_sat;
        end
      end
      S_MUL_P:   tp <= mul_p[31:0];
      S_MUL_I:   ti <= mul_p[31:0];
      S_MUL_D:   td <= mul_p[47:0];
      default: ;
    endcase
  end

  // Result register: holds the finished result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.drive_total <= total_sat;
      result.term_p      <= tp;
      result.term_i      <= ti;
      result.term_d      <= td;
    end
  end

`ifndef NO_ASSERTIONS
  // The divider only finishes while the sequencer is waiting for it.
  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_INT || state == S_DIV_DER))
    else $error("divider finished outside a divide state");

  // A sample is accepted only when the sequencer is free, and it is busy right after.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("sample accepted while a previous one is still in progress");

  // The clamped integral never exceeds the configured limit.
  a_integral_clamped: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL_I) |->
      (iterm <= $signed({1'b0, integral_limit}) && iterm >= -$signed({1'b0, integral_limit})))
    else $error("integral term outside its limit");

  // A result still waiting in the output register holds the sequencer in the summing step.
  a_sum_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM && result.valid && !result.ready) |=> (state == S_SUM))
    else $error("result register overwritten before it was taken");
`endif

endmodule

FILE: hdl/ipid_div.sv
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Depends on ipid_pkg for its widths.
module ipid_div
  import ipid_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 done,
  output logic [DIV_W-1:0]     quotient
);

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] divr;
  logic [DIV_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] count;
  logic                 busy;

  logic [DIVISOR_W:0]   r1, r2;
  logic                 ge1, ge2;
  logic [DIVISOR_W-1:0] rem1, rem_next;
  logic [DIV_W-1:0]     quo1, quo_next;

  // Two dependent restoring steps: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    r1   = {rem, quo[DIV_W-1]};
    ge1  = (r1 >= {1'b0, divr});
    rem1 = ge1 ? DIVISOR_W'(r1 - {1'b0, divr}) : r1[DIVISOR_W-1:0];
    quo1 = {quo[DIV_W-2:0], ge1};

    r2       = {rem1, quo1[DIV_W-1]};
    ge2      = (r2 >= {1'b0, divr});
    rem_next = ge2 ? DIVISOR_W'(r2 - {1'b0, divr}) : r2[DIVISOR_W-1:0];
    quo_next = {quo1[DIV_W-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      divr <= divisor;
      quo  <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

FILE: verif/integer_pid_controller_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for integer_pid_controller: directed table, then random requests.
// Depends on ipid_pkg, ipid_if and the controller RTL; needs no files or arguments.
module integer_pid_controller_tb;
  import ipid_pkg::*;

  // The register index above the list; writes to it must leave every register alone.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Quiet time allowed at the very end for any stray result request to show itself;
  // it is longer than one sample takes inside the block.
  localparam int LATENCY = 70;
  // Idle cycles before reprogramming, once all results have drained.
  localparam int SETTLE = 4;
  localparam int RANDOM_ITEMS = 1530;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int IDLE_PCT = 37;

  typedef struct packed {
    logic signed [47:0] total;
    logic signed [31:0] p;
    logic signed [31:0] i;
    logic signed [47:0] d;
  } drive_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_TYPED} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    logic signed [15:0]     tv;
    logic signed [15:0]     mv;
    drive_t                 want;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ipid_sample_if smp ();
  ipid_result_if res ();

  integer_pid_controller u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (smp),
    .result    (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copies of the configuration registers, kept in step with every write.
  logic signed [15:0] kp, ki, kd;
  logic [15:0]        step_reg, iscale_reg, dscale_reg;
  logic [14:0]        lim_reg;

  // Controller state as the predictor sees it: the integrated error and the error of
  // the previous sample.
  longint err_sum;
  longint prev_err;

  drive_t pending_drive[$];
  int     fault_count = 0;
  int     cycle_count = 0;
  int     idle_pct = IDLE_PCT;
  bit     cfg_busy = 1'b0;

  function automatic longint clip(input longint x, input longint lo, input longint hi);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // Works out the result of one sample and advances the predictor state. A time step or
  // integral scale of zero counts as one; a derivative scale of zero is used as it stands.
  function automatic drive_t compute_drive(input logic signed [15:0] tv,
                                           input logic signed [15:0] mv);
    longint err, dt, isc, lim, integ, deriv, tp, ti, td, total;
    drive_t r;
    err = longint'(tv) - longint'(mv);
    dt  = (step_reg == 16'd0) ? 64'sd1 : longint'(step_reg);
    isc = (iscale_reg == 16'd0) ? 64'sd1 : longint'(iscale_reg);
    lim = longint'(lim_reg);

    err_sum = clip(err_sum + err * dt, longint'(ACC_MIN), longint'(ACC_MAX));
    // Signed division truncates toward zero, as the block must.
    integ = clip(err_sum / isc, -lim, lim);
    deriv = clip(((err - prev_err) * longint'(dscale_reg)) / dt,
                 longint'(D_MIN), longint'(D_MAX));

    tp = longint'(kp) * err;
    ti = longint'(ki) * integ;
    td = longint'(kd) * deriv;
    total = clip(tp + ti + td, longint'(ACC_MIN), longint'(ACC_MAX));
    prev_err = err;

    r.total = total[47:0];
    r.p     = tp[31:0];
    r.i     = ti[31:0];
    r.d     = td[47:0];
    return r;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_GAIN_P:           kp = data;
      REG_GAIN_I:           ki = data;
      REG_GAIN_D:           kd = data;
      REG_TIME_STEP:        step_reg = data;
      REG_INTEGRAL_SCALE:   iscale_reg = data;
      REG_DERIVATIVE_SCALE: dscale_reg = data;
      REG_INTEGRAL_LIMIT:   lim_reg = data[14:0];
      default: ;
    endcase
  endfunction

  // Gains: the two extremes, zero, small values of either sign, or anything at all.
  function automatic logic [15:0] pick_gain();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($urandom_range(31) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  // Time step and scales: mostly small so that the integral and derivative paths stay
  // out of saturation, with zero, one and the maximum mixed in.
  function automatic logic [15:0] pick_scale();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'hFFFF;
      3, 4, 5: return 16'($urandom_range(20, 2));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(64, 1));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_extreme();
    case ($urandom_range(4))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  function automatic row_t wr_row(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic row_t sample_row(input logic signed [15:0] tv,
                                      input logic signed [15:0] mv);
    row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.tv   = tv;
    r.mv   = mv;
    return r;
  endfunction

  function automatic row_t typed_row(input logic signed [15:0] tv,
                                     input logic signed [15:0] mv,
                                     input logic signed [47:0] total,
                                     input logic signed [31:0] p,
                                     input logic signed [31:0] i,
                                     input logic signed [47:0] d);
    row_t r;
    r = '0;
    r.kind       = ROW_TYPED;
    r.tv         = tv;
    r.mv         = mv;
    r.want.total = total;
    r.want.p     = p;
    r.want.i     = i;
    r.want.d     = d;
    return r;
  endfunction

  // Lowers the sample valid, waits until every expected result request has been taken,
  // and then waits the number of further cycles given by settle.
  task automatic drain(input int settle);
    smp.valid <= 1'b0;
    @(posedge clk);
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // One register write per clock edge. The write enable stays high across a run of
  // writes and is lowered by the next sample request.
  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_busy  = 1'b1;
    @(posedge clk);
    apply_reg(idx, data);
  endtask

  // Offers one sample request, with random idle cycles in front of it, and records the
  // expected result once it has been accepted. A row of the directed table may supply
  // its expectation directly; the predictor still runs so that its state moves on.
  task automatic send_sample(input logic signed [15:0] tv, input logic signed [15:0] mv,
                             input bit use_want, input drive_t want);
    drive_t got;
    if (cfg_busy) begin
      cfg_write <= 1'b0;
      cfg_busy  = 1'b0;
    end
    while ($urandom_range(99) < idle_pct) begin
      smp.valid          <= 1'b0;
      smp.target_value   <= 16'($urandom);
      smp.measured_value <= 16'($urandom);
      @(posedge clk);
    end
    smp.valid          <= 1'b1;
    smp.target_value   <= tv;
    smp.measured_value <= mv;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    got = compute_drive(tv, mv);
    pending_drive.push_back(use_want ? want : got);
  endtask

  task automatic compare_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fault_count++;
    end
  endtask

  // The result side stalls with the same probability as the sample side idles.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      res.ready <= !rst && ($urandom_range(99) >= idle_pct);
    end
  end

  // Every accepted result request is matched against the oldest expectation.
  always @(posedge clk) begin : check_results
    drive_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_drive.size() == 0) begin
        $display("%0t: result request with nothing expected, drive_total %0d",
                 $time, res.drive_total);
        fault_count++;
      end else begin
        want = pending_drive.pop_front();
        compare_field("drive_total", want.total, res.drive_total);
        compare_field("term_p", want.p, res.term_p);
        compare_field("term_i", want.i, res.term_i);
        compare_field("term_d", want.d, res.term_d);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    row_t               plan[$];
    logic signed [15:0] setpoint, plant, tv, mv;
    int                 sent, burst, mode;

    // Everything the block sees is known from time zero; reset is released once the directed table has been built.
    rst                = 1'b1;
    cfg_write          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    smp.valid          = 1'b0;
    smp.target_value   = '0;
    smp.measured_value = '0;

    kp         = '0;
    ki         = '0;
    kd         = '0;
    step_reg   = TIME_STEP_RST;
    iscale_reg = INTEGRAL_SCALE_RST;
    dscale_reg = DERIV_SCALE_RST;
    lim_reg    = INTEGRAL_LIMIT_RST;
    err_sum    = 0;
    prev_err   = 0;
    setpoint   = '0;
    plant      = '0;
    sent       = 0;

    // Directed table. Rows with typed-in results follow from the reset values and from
    // the extremes: while the gains are zero every term is zero; full-scale errors
    // against the extreme proportional gains; a huge error change saturating the
    // derivative in both directions; a derivative scale of zero; a time step and an
    // integral scale of zero behaving as one; the integral clamped negative under both
    // gain signs and zeroed by a zero limit. Bit 15 of the limit write must be dropped.
    plan.push_back(typed_row(16'sd32767, -16'sd32768, 48'sd0, 32'sd0, 32'sd0, 48'sd0));
    plan.push_back(typed_row(-16'sd32768, 16'sd32767, 48'sd0, 32'sd0, 32'sd0, 48'sd0));
    plan.push_back(wr_row(REG_GAIN_P, 16'h8000));
    plan.push_back(typed_row(16'sd32767, -16'sd32768, -48'sd2147450880,
                             -32'sd2147450880, 32'sd0, 48'sd0));
    plan.push_back(wr_row(REG_GAIN_P, 16'h7FFF));
    plan.push_back(typed_row(-16'sd32768, 16'sd32767, -48'sd2147385345,
                             -32'sd2147385345, 32'sd0, 48'sd0));
    plan.push_back(wr_row(REG_GAIN_P, 16'h0000));
    plan.push_back(wr_row(REG_GAIN_D, 16'h7FFF));
    plan.push_back(wr_row(REG_DERIVATIVE_SCALE, 16'hFFFF));
    plan.push_back(typed_row(16'sd32767, -16'sd32768, 48'sd70366596661249,
                             32'sd0, 32'sd0, 48'sd70366596661249));
    plan.push_back(wr_row(REG_GAIN_D, 16'h8000));
    plan.push_back(typed_row(-16'sd32768, 16'sd32767, 48'sd70368744177664,
                             32'sd0, 32'sd0, 48'sd70368744177664));
    plan.push_back(wr_row(REG_DERIVATIVE_SCALE, 16'h0000));
    plan.push_back(typed_row(16'sd0, 16'sd0, 48'sd0, 32'sd0, 32'sd0, 48'sd0));
    plan.push_back(wr_row(REG_GAIN_D, 16'h0000));
    plan.push_back(wr_row(REG_GAIN_I, 16'h7FFF));
    plan.push_back(wr_row(REG_TIME_STEP, 16'h0000));
    plan.push_back(wr_row(REG_INTEGRAL_SCALE, 16'h0000));
    plan.push_back(wr_row(REG_DERIVATIVE_SCALE, 16'h0001));
    plan.push_back(typed_row(16'sd1000, 16'sd0, 48'sd32767000,
                             32'sd0, 32'sd32767000, 48'sd0));
    plan.push_back(typed_row(-16'sd32768, 16'sd32767, -48'sd1073676289,
                             32'sd0, -32'sd1073676289, 48'sd0));
    plan.push_back(wr_row(REG_GAIN_I, 16'h8000));
    plan.push_back(wr_row(REG_INTEGRAL_LIMIT, 16'hFFFF));
    plan.push_back(typed_row(-16'sd32768, 16'sd32767, 48'sd1073709056,
                             32'sd0, 32'sd1073709056, 48'sd0));
    plan.push_back(wr_row(REG_INTEGRAL_LIMIT, 16'h0000));
    plan.push_back(typed_row(16'sd5, 16'sd0, 48'sd0, 32'sd0, 32'sd0, 48'sd0));
    // From here on the predictor supplies the expectations.
    plan.push_back(wr_row(REG_UNUSED, 16'hFFFF));
    plan.push_back(wr_row(REG_TIME_STEP, 16'hFFFF));
    plan.push_back(wr_row(REG_INTEGRAL_SCALE, 16'hFFFF));
    plan.push_back(wr_row(REG_INTEGRAL_LIMIT, 16'h4000));
    plan.push_back(wr_row(REG_GAIN_P, 16'h7FFF));
    plan.push_back(wr_row(REG_GAIN_D, 16'h7FFF));
    plan.push_back(sample_row(16'sd32767, -16'sd32768));
    plan.push_back(sample_row(-16'sd32768, 16'sd32767));
    plan.push_back(sample_row(16'sd0, 16'sd0));
    plan.push_back(sample_row(16'sd123, -16'sd456));
    plan.push_back(sample_row(-16'sd1, 16'sd1));
    // Odd scales, so that negative quotients have to truncate toward zero.
    plan.push_back(wr_row(REG_TIME_STEP, 16'd7));
    plan.push_back(wr_row(REG_INTEGRAL_SCALE, 16'd3));
    plan.push_back(wr_row(REG_DERIVATIVE_SCALE, 16'd3));
    plan.push_back(wr_row(REG_GAIN_D, 16'hFFFF));
    plan.push_back(wr_row(REG_GAIN_I, 16'h0001));
    plan.push_back(wr_row(REG_INTEGRAL_LIMIT, 16'h7FFF));
    plan.push_back(sample_row(-16'sd10, 16'sd0));
    plan.push_back(sample_row(16'sd10, 16'sd0));
    plan.push_back(sample_row(-16'sd5, 16'sd3));
    plan.push_back(sample_row(16'sd32767, 16'sd32767));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_WRITE) begin
        if (!cfg_busy) drain(SETTLE);
        program_reg(plan[k].idx, plan[k].data);
      end else begin
        send_sample(plan[k].tv, plan[k].mv, plan[k].kind == ROW_TYPED, plan[k].want);
      end
    end

    // Random part: phases of fresh settings, each followed by a burst of samples. Most
    // samples come from a simple closed loop, in which the measurement chases a
    // wandering setpoint, so that the integral builds up gradually rather than
    // saturating at once; the rest are unrelated values and extremes.
    while (sent < RANDOM_ITEMS) begin
      drain(SETTLE);
      program_reg(REG_GAIN_P, pick_gain());
      program_reg(REG_GAIN_I, pick_gain());
      program_reg(REG_GAIN_D, pick_gain());
      program_reg(REG_TIME_STEP, pick_scale());
      program_reg(REG_INTEGRAL_SCALE, pick_scale());
      program_reg(REG_DERIVATIVE_SCALE, pick_scale());
      program_reg(REG_INTEGRAL_LIMIT, pick_limit());
      if ($urandom_range(3) == 0) program_reg(REG_UNUSED, 16'($urandom));

      burst = $urandom_range(180, 30);
      for (int n = 0; n < burst && sent < RANDOM_ITEMS; n++) begin
        // A long stretch with neither side idling, to run the block back to back.
        idle_pct = (sent >= 500 && sent < 800) ? 0 : IDLE_PCT;
        // Now and then hold off until the block has delivered everything.
        if ($urandom_range(99) == 0) drain(0);

        mode = $urandom_range(99);
        if (mode < 55) begin
          if ($urandom_range(15) == 0) setpoint = 16'($urandom);
          else setpoint = setpoint + 16'($urandom_range(63) - 32);
          plant = plant + ((setpoint - plant) >>> 3) + 16'($urandom_range(15) - 8);
          tv = setpoint;
          mv = plant;
        end else if (mode < 85) begin
          tv = 16'($urandom);
          mv = 16'($urandom);
        end else begin
          tv = pick_extreme();
          mv = pick_extreme();
        end
        send_sample(tv, mv, 1'b0, '0);
        sent++;
      end
    end

    drain(LATENCY);
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/ipid_pkg.sv
hdl/ipid_if.sv
hdl/ipid_div.sv
hdl/integer_pid_controller.sv
verif/integer_pid_controller_tb.sv
